// ===== sv/pram_pkg.sv =====
package pram_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int CFG_W       = 9;
    localparam int SUB_W       = 8;
    localparam int IDX_W       = 8;
    localparam int COLOR_W     = 32;
    localparam int BGR_W       = 15;
    localparam int ADDR_FULL_W = CFG_W + SUB_W + 1;

    localparam logic [CFG_W-1:0]   CFG_RESET    = CFG_W'(16);
    localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

    typedef enum logic [1:0] {
        OP_WR_ARGB = 2'd0,
        OP_WR_BGR  = 2'd1,
        OP_RD_ARGB = 2'd2,
        OP_RD_BGR  = 2'd3
    } t_opcode;

endpackage

// ===== sv/palette_ram_with_bgr555_convert.sv =====
// Palette RAM of PALETTE_ENTRIES ARGB32 words, addressed as colors per subpalette times
// subpalette number plus entry index. After reset the block fills the whole RAM with
// opaque black and takes no item until that is done. Each item then goes through these
// steps: it is taken in and its address computed, the single RAM port reads or writes,
// and the read word is converted and loaded into the output register once it is free.
// A result that waits at the output does not keep the next item from entering. Addresses
// past the last entry return zero with the error flag set and leave the RAM unchanged.
module palette_ram_with_bgr555_convert
    import pram_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: subpalette_number, entry_index, color_in.
    input  logic [47:0]          s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic [1:0]           s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: color_out.
    output logic [COLOR_W-1:0]   m_axis_tdata,
    // Fields from bit 0: address_error.
    output logic                 m_axis_tuser
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_RESULT
    } t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [CFG_W-1:0]     r_cfg;

    t_opcode              r_op;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_err;
    logic [COLOR_W-1:0]   r_color;

    logic [COLOR_W-1:0]   r_mem [PALETTE_ENTRIES];
    logic [COLOR_W-1:0]   r_rd_data;

    logic                 r_out_valid;
    logic [COLOR_W-1:0]   r_out_data;
    logic                 r_out_err;

    logic [ADDR_FULL_W-1:0] n_addr_full;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_addr;
    logic [COLOR_W-1:0]     mem_wdata;
    logic [COLOR_W-1:0]     wr_expanded;
    logic [BGR_W-1:0]       rd_narrowed;
    logic [COLOR_W-1:0]     n_out_data;
    logic                   out_free;
    logic                   in_accept;

    pram_fmt u_fmt (
        .i_bgr555 (r_color[BGR_W-1:0]),
        .o_argb   (wr_expanded),
        .i_argb   (r_rd_data),
        .o_bgr555 (rd_narrowed)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;

    assign n_addr_full = ADDR_FULL_W'(r_cfg) * ADDR_FULL_W'(s_axis_tdata[SUB_W-1:0])
                       + ADDR_FULL_W'(s_axis_tdata[SUB_W+IDX_W-1:SUB_W]);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = r_color;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = OPAQUE_BLACK;
        end else if (r_state == ST_ACCESS && !r_err) begin
            if (r_op == OP_WR_ARGB || r_op == OP_WR_BGR) begin
                mem_we = 1'b1;
            end
            if (r_op == OP_WR_BGR) begin
                mem_wdata = wr_expanded;
            end
        end
    end

    always_comb begin
        n_out_data = '0;
        if (!r_err) begin
            unique case (r_op)
                OP_RD_ARGB: n_out_data = r_rd_data;
                OP_RD_BGR:  n_out_data = COLOR_W'(rd_narrowed);
                default:    n_out_data = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= t_opcode'(s_axis_tuser);
            r_addr  <= n_addr_full[ADDR_W-1:0];
            r_err   <= (n_addr_full >= ADDR_FULL_W'(PALETTE_ENTRIES));
            r_color <= s_axis_tdata[SUB_W+IDX_W+COLOR_W-1:SUB_W+IDX_W];
        end
        if (r_state == ST_RESULT && out_free) begin
            r_out_data <= n_out_data;
            r_out_err  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(PALETTE_ENTRIES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_ACCESS;
                    end
                end
                ST_ACCESS: begin
                    r_state <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/pram_fmt.sv =====
module pram_fmt
    import pram_pkg::*;
(
    input  logic [BGR_W-1:0]   i_bgr555,
    output logic [COLOR_W-1:0] o_argb,
    input  logic [COLOR_W-1:0] i_argb,
    output logic [BGR_W-1:0]   o_bgr555
);

    function automatic logic [7:0] widen5(input logic [4:0] c5);
        return {c5, c5[4:2]};
    endfunction

    function automatic logic [4:0] narrow8(input logic [7:0] c8);
        logic [8:0] sum;
        sum = (c8 <= 8'd248) ? ({1'b0, c8} + 9'd4) : {1'b0, c8};
        return sum[7:3];
    endfunction

    assign o_argb = OPAQUE_BLACK | {8'h00, widen5(i_bgr555[4:0]),
                                    widen5(i_bgr555[9:5]), widen5(i_bgr555[14:10])};

    assign o_bgr555 = {narrow8(i_argb[7:0]), narrow8(i_argb[15:8]), narrow8(i_argb[23:16])};

endmodule
